// ===== rtl/core/adam_pkg.sv =====
// ----------------------------------------------------------------------------
// adam_pkg: shared types and constants for the Adam weight update block
// Fixed-point formats, pipeline depths and the structs that move between
// the moment, square-root and divider stages.
// ----------------------------------------------------------------------------
`default_nettype none

package adam_pkg;

  // Data format: signed Q8.24
  localparam int unsigned DataW  = 32;
  localparam int unsigned FracW  = 24;
  localparam int unsigned MomW   = DataW - 1;
  localparam int unsigned BetaW  = 16;
  localparam int unsigned StepW  = 31;
  localparam int unsigned EpsW   = 16;
  localparam int unsigned CfgW   = 32;

  // Square root of rn * 2^FracW: 56-bit radicand, one root bit per stage
  localparam int unsigned SqXW   = 2 * ((MomW + FracW + 1) / 2);
  localparam int unsigned RootW  = SqXW / 2;
  localparam int unsigned SqRemW = RootW + 2;

  // Step times |m'| and the restoring divider, one quotient bit per stage
  localparam int unsigned NumW   = StepW + DataW;
  localparam int unsigned DivW   = NumW + 1;
  localparam int unsigned DenW   = RootW + 1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BETA_ONE  = 2'd0,
    CFG_BETA_TWO  = 2'd1,
    CFG_STEP_SIZE = 2'd2,
    CFG_EPSILON   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [BetaW-1:0] beta_one;
    logic [BetaW-1:0] beta_two;
    logic [StepW-1:0] step_size;
    logic [EpsW-1:0]  epsilon;
  } cfg_t;

  // Moment stage result, carried alongside the root and the quotient
  typedef struct packed {
    logic signed [DataW-1:0] mn;
    logic [MomW-1:0]         rn;
    logic [NumW-1:0]         num;
    logic signed [DataW-1:0] w;
    logic                    sat;
  } mom_out_t;

  // One finished result
  typedef struct packed {
    logic signed [DataW-1:0] mn;
    logic [MomW-1:0]         rn;
    logic signed [DataW-1:0] wn;
    logic                    sat;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/adam_mom.sv =====
// ----------------------------------------------------------------------------
// adam_mom: first and second moment update
// Four register stages: products, first moment and g*g rounding,
// second moment product and step*|m'|, second moment sum and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module adam_mom (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire adam_pkg::cfg_t                  cfg_i,
  input  wire logic                            in_valid_i,
  input  wire logic signed [adam_pkg::DataW-1:0] gradient_i,
  input  wire logic signed [adam_pkg::DataW-1:0] first_moment_i,
  input  wire logic [adam_pkg::MomW-1:0]       second_moment_i,
  input  wire logic signed [adam_pkg::DataW-1:0] weight_i,
  output logic                                 out_valid_o,
  output adam_pkg::mom_out_t                   out_o
);

  logic [16:0] c1, c2;
  logic [31:0] ag;

  logic signed [48:0] pm1_d;
  logic signed [49:0] pm2_d;
  logic [63:0]        pgg_d;
  logic [46:0]        pr_d;

  logic               s1_v_q;
  logic signed [48:0] s1_pm1_q;
  logic signed [49:0] s1_pm2_q;
  logic [63:0]        s1_pgg_q;
  logic [46:0]        s1_pr_q;
  logic signed [31:0] s1_w_q;

  logic signed [49:0] macc;
  logic [33:0]        mfull;
  logic [63:0]        ggsum;
  logic signed [31:0] mn_d;
  logic               msat_d;

  logic               s2_v_q;
  logic signed [31:0] s2_mn_q;
  logic               s2_sat_q;
  logic [39:0]        s2_gg_q;
  logic [46:0]        s2_pr_q;
  logic signed [31:0] s2_w_q;

  logic [31:0]        am;
  logic [56:0]        prb_d;
  logic [62:0]        num_d;

  logic               s3_v_q;
  logic signed [31:0] s3_mn_q;
  logic               s3_sat_q;
  logic [56:0]        s3_prb_q;
  logic [46:0]        s3_pr_q;
  logic [62:0]        s3_num_q;
  logic signed [31:0] s3_w_q;

  logic [57:0]        racc;
  logic [41:0]        rfull;
  logic [30:0]        rn_d;
  logic               rsat_d;

  logic               s4_v_q;
  adam_pkg::mom_out_t s4_q;

  // Stage 1: products
  assign c1 = 17'h10000 - {1'b0, cfg_i.beta_one};
  assign c2 = 17'h10000 - {1'b0, cfg_i.beta_two};
  assign ag = gradient_i[31] ? 32'(-gradient_i) : 32'(gradient_i);

  always_comb begin
    pm1_d = $signed({1'b0, cfg_i.beta_one}) * first_moment_i;
    pm2_d = $signed({1'b0, c1}) * gradient_i;
    pgg_d = ag * ag;
    pr_d  = cfg_i.beta_two * second_moment_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_pm1_q <= pm1_d;
      s1_pm2_q <= pm2_d;
      s1_pgg_q <= pgg_d;
      s1_pr_q  <= pr_d;
      s1_w_q   <= weight_i;
    end
  end

  // Stage 2: round and clamp first moment, round g*g
  always_comb begin
    macc  = $signed({s1_pm1_q[48], s1_pm1_q}) + s1_pm2_q + 50'sd32768;
    mfull = macc[49:16];
    ggsum = s1_pgg_q + 64'd8388608;
    if (mfull[33:31] == 3'b000 || mfull[33:31] == 3'b111) begin
      mn_d   = mfull[31:0];
      msat_d = 1'b0;
    end else if (mfull[33]) begin
      mn_d   = 32'sh80000000;
      msat_d = 1'b1;
    end else begin
      mn_d   = 32'sh7fffffff;
      msat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en_i) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_mn_q  <= mn_d;
      s2_sat_q <= msat_d;
      s2_gg_q  <= ggsum[63:24];
      s2_pr_q  <= s1_pr_q;
      s2_w_q   <= s1_w_q;
    end
  end

  // Stage 3: second moment product and step times |m'|
  always_comb begin
    am    = s2_mn_q[31] ? 32'(-s2_mn_q) : 32'(s2_mn_q);
    prb_d = c2 * s2_gg_q;
    num_d = cfg_i.step_size * am;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en_i) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_mn_q  <= s2_mn_q;
      s3_sat_q <= s2_sat_q;
      s3_prb_q <= prb_d;
      s3_pr_q  <= s2_pr_q;
      s3_num_q <= num_d;
      s3_w_q   <= s2_w_q;
    end
  end

  // Stage 4: second moment sum, round and clamp
  always_comb begin
    racc  = 58'(s3_pr_q) + 58'(s3_prb_q) + 58'd32768;
    rfull = racc[57:16];
    if (|rfull[41:31]) begin
      rn_d   = 31'h7fffffff;
      rsat_d = 1'b1;
    end else begin
      rn_d   = rfull[30:0];
      rsat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en_i) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_q.mn  <= s3_mn_q;
      s4_q.rn  <= rn_d;
      s4_q.num <= s3_num_q;
      s4_q.w   <= s3_w_q;
      s4_q.sat <= s3_sat_q | rsat_d;
    end
  end

  assign out_valid_o = s4_v_q;
  assign out_o       = s4_q;

endmodule

`default_nettype wire

// ===== rtl/core/adam_sqrt.sv =====
// ----------------------------------------------------------------------------
// adam_sqrt: pipelined integer square root
// Takes the root of rn * 2^FracW, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module adam_sqrt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      in_valid_i,
  input  wire adam_pkg::mom_out_t        in_i,
  output logic                           out_valid_o,
  output logic [adam_pkg::RootW-1:0]     out_root_o,
  output adam_pkg::mom_out_t             out_side_o
);

  localparam int unsigned N = adam_pkg::RootW;

  logic                        v_q    [N];
  logic [adam_pkg::SqXW-1:0]   x_q    [N];
  logic [adam_pkg::SqRemW-1:0] rem_q  [N];
  logic [N-1:0]                root_q [N];
  adam_pkg::mom_out_t          side_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic                        prev_v;
    logic [adam_pkg::SqXW-1:0]   prev_x;
    logic [adam_pkg::SqRemW-1:0] prev_rem;
    logic [N-1:0]                prev_root;
    adam_pkg::mom_out_t          prev_side;
    logic [adam_pkg::SqRemW+1:0] tmp;
    logic [adam_pkg::SqRemW+1:0] trial;
    logic                        ge;

    // Select stage input
    if (i == 0) begin : g_first
      assign prev_v    = in_valid_i;
      assign prev_x    = {1'b0, in_i.rn, {adam_pkg::FracW{1'b0}}};
      assign prev_rem  = '0;
      assign prev_root = '0;
      assign prev_side = in_i;
    end else begin : g_next
      assign prev_v    = v_q[i-1];
      assign prev_x    = x_q[i-1];
      assign prev_rem  = rem_q[i-1];
      assign prev_root = root_q[i-1];
      assign prev_side = side_q[i-1];
    end

    // Bring down two radicand bits, try the next root bit
    assign tmp   = {prev_rem, prev_x[adam_pkg::SqXW-1 -: 2]};
    assign trial = {2'b00, prev_root, 2'b01};
    assign ge    = (tmp >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]    <= {prev_x[adam_pkg::SqXW-3:0], 2'b00};
        rem_q[i]  <= ge ? adam_pkg::SqRemW'(tmp - trial) : adam_pkg::SqRemW'(tmp);
        root_q[i] <= {prev_root[N-2:0], ge};
        side_q[i] <= prev_side;
      end
    end
  end

  assign out_valid_o = v_q[N-1];
  assign out_root_o  = root_q[N-1];
  assign out_side_o  = side_q[N-1];

endmodule

`default_nettype wire

// ===== rtl/core/adam_div.sv =====
// ----------------------------------------------------------------------------
// adam_div: pipelined rounded divider
// Forms d = root + epsilon and (num + d/2) / d with a restoring divider,
// one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module adam_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic [adam_pkg::EpsW-1:0] epsilon_i,
  input  wire logic                      in_valid_i,
  input  wire logic [adam_pkg::RootW-1:0] in_root_i,
  input  wire adam_pkg::mom_out_t        in_side_i,
  output logic                           out_valid_o,
  output logic [adam_pkg::DivW-1:0]      out_quot_o,
  output adam_pkg::mom_out_t             out_side_o
);

  localparam int unsigned N = adam_pkg::DivW;

  logic [adam_pkg::EpsW-1:0] eps_eff;

  logic                      a_v_q;
  logic [adam_pkg::DenW-1:0] a_d_q;
  adam_pkg::mom_out_t        a_side_q;

  logic                      b_v_q;
  logic [N-1:0]              b_nq_q;
  logic [adam_pkg::DenW-1:0] b_d_q;
  adam_pkg::mom_out_t        b_side_q;

  logic                      v_q    [N];
  logic [N-1:0]              nq_q   [N];
  logic [adam_pkg::DenW-1:0] rem_q  [N];
  logic [adam_pkg::DenW-1:0] d_q    [N];
  adam_pkg::mom_out_t        side_q [N];

  // Zero epsilon acts as one
  assign eps_eff = (epsilon_i == '0) ? adam_pkg::EpsW'(1) : epsilon_i;

  // Prep stage A: divisor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_d_q    <= adam_pkg::DenW'(in_root_i) + adam_pkg::DenW'(eps_eff);
      a_side_q <= in_side_i;
      // Prep stage B: add half the divisor for round to nearest
      b_nq_q   <= N'(a_side_q.num) + N'(a_d_q[adam_pkg::DenW-1:1]);
      b_d_q    <= a_d_q;
      b_side_q <= a_side_q;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic                      prev_v;
    logic [N-1:0]              prev_nq;
    logic [adam_pkg::DenW-1:0] prev_rem;
    logic [adam_pkg::DenW-1:0] prev_d;
    adam_pkg::mom_out_t        prev_side;
    logic [adam_pkg::DenW:0]   tmp;
    logic                      ge;

    // Select stage input
    if (i == 0) begin : g_first
      assign prev_v    = b_v_q;
      assign prev_nq   = b_nq_q;
      assign prev_rem  = '0;
      assign prev_d    = b_d_q;
      assign prev_side = b_side_q;
    end else begin : g_next
      assign prev_v    = v_q[i-1];
      assign prev_nq   = nq_q[i-1];
      assign prev_rem  = rem_q[i-1];
      assign prev_d    = d_q[i-1];
      assign prev_side = side_q[i-1];
    end

    // Shift in the next dividend bit, subtract when it fits
    assign tmp = {prev_rem, prev_nq[N-1]};
    assign ge  = (tmp >= {1'b0, prev_d});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[i]   <= {prev_nq[N-2:0], ge};
        rem_q[i]  <= ge ? adam_pkg::DenW'(tmp - {1'b0, prev_d}) : tmp[adam_pkg::DenW-1:0];
        d_q[i]    <= prev_d;
        side_q[i] <= prev_side;
      end
    end
  end

  assign out_valid_o = v_q[N-1];
  assign out_quot_o  = nq_q[N-1];
  assign out_side_o  = side_q[N-1];

endmodule

`default_nettype wire

// ===== rtl/core/adam_weight_update.sv =====
// ----------------------------------------------------------------------------
// adam_weight_update: Adam optimizer update, one tensor element per cycle unless stalled
// Moments, square root, rounded division and saturating weight update in
// signed Q8.24, followed by a skid stage on the result side.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  input     in_valid_i / in_stall_o      gradient, first/second moment, weight
//  result    out_valid_o / out_stall_i    new moments, new weight, saturated
//  config    cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
//  One item enters per cycle while in_stall_o is low; the stages are 4 moment
//  stages, 28 square-root stages (one root bit each), 66 divider stages (2 prep,
//  one quotient bit per stage), the weight stage and the output register.
//  The whole pipeline advances together; it holds only while the skid
//  register is full. Reset clears the valid bits and loads the register
//  defaults; configuration always accepts a write.
// ----------------------------------------------------------------------------
`default_nettype none

module adam_weight_update (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [1:0]                        cfg_index_i,
  input  wire logic [adam_pkg::CfgW-1:0]         cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [adam_pkg::DataW-1:0] gradient_i,
  input  wire logic signed [adam_pkg::DataW-1:0] first_moment_i,
  input  wire logic [adam_pkg::MomW-1:0]         second_moment_i,
  input  wire logic signed [adam_pkg::DataW-1:0] weight_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [adam_pkg::DataW-1:0]      new_first_moment_o,
  output logic [adam_pkg::MomW-1:0]              new_second_moment_o,
  output logic signed [adam_pkg::DataW-1:0]      new_weight_o,
  output logic                                   saturated_o
);

  adam_pkg::cfg_t cfg_q;

  logic en;

  logic                  mom_v;
  adam_pkg::mom_out_t    mom_out;
  logic                  sq_v;
  logic [adam_pkg::RootW-1:0] sq_root;
  adam_pkg::mom_out_t    sq_side;
  logic                  dv_v;
  logic [adam_pkg::DivW-1:0]  dv_quot;
  adam_pkg::mom_out_t    dv_side;

  logic signed [65:0]    wfull;
  logic signed [31:0]    wn_d;
  logic                  wsat_d;

  logic                  t_v_q;
  adam_pkg::res_t        t_q;
  logic                  skid_v_q;
  adam_pkg::res_t        skid_q;
  logic                  out_v_q;
  adam_pkg::res_t        out_q;
  logic                  handoff;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beta_one  <= 16'd58982;
      cfg_q.beta_two  <= 16'd65470;
      cfg_q.step_size <= 31'd5305;
      cfg_q.epsilon   <= 16'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (adam_pkg::cfg_reg_e'(cfg_index_i))
        adam_pkg::CFG_BETA_ONE:  cfg_q.beta_one  <= cfg_data_i[adam_pkg::BetaW-1:0];
        adam_pkg::CFG_BETA_TWO:  cfg_q.beta_two  <= cfg_data_i[adam_pkg::BetaW-1:0];
        adam_pkg::CFG_STEP_SIZE: cfg_q.step_size <= cfg_data_i[adam_pkg::StepW-1:0];
        adam_pkg::CFG_EPSILON:   cfg_q.epsilon   <= cfg_data_i[adam_pkg::EpsW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless the skid register holds a result
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  adam_mom u_mom (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .gradient_i      (gradient_i),
    .first_moment_i  (first_moment_i),
    .second_moment_i (second_moment_i),
    .weight_i        (weight_i),
    .out_valid_o     (mom_v),
    .out_o           (mom_out)
  );

  adam_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (mom_v),
    .in_i        (mom_out),
    .out_valid_o (sq_v),
    .out_root_o  (sq_root),
    .out_side_o  (sq_side)
  );

  adam_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .epsilon_i   (cfg_q.epsilon),
    .in_valid_i  (sq_v),
    .in_root_i   (sq_root),
    .in_side_i   (sq_side),
    .out_valid_o (dv_v),
    .out_quot_o  (dv_quot),
    .out_side_o  (dv_side)
  );

  // Weight update: move against the sign of m', clamp to range
  always_comb begin
    if (dv_side.mn[31]) begin
      wfull = $signed({{34{dv_side.w[31]}}, dv_side.w}) + $signed({2'b00, dv_quot});
    end else begin
      wfull = $signed({{34{dv_side.w[31]}}, dv_side.w}) - $signed({2'b00, dv_quot});
    end
    if (wfull[65:31] == '0 || wfull[65:31] == '1) begin
      wn_d   = wfull[31:0];
      wsat_d = 1'b0;
    end else if (wfull[65]) begin
      wn_d   = 32'sh80000000;
      wsat_d = 1'b1;
    end else begin
      wn_d   = 32'sh7fffffff;
      wsat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_v_q <= 1'b0;
    end else if (en) begin
      t_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q.mn  <= dv_side.mn;
      t_q.rn  <= dv_side.rn;
      t_q.wn  <= wn_d;
      t_q.sat <= dv_side.sat | wsat_d;
    end
  end

  // Output register with skid: drain skid first, else take the pipeline tail
  assign handoff = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (handoff) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (t_v_q) begin
      if (handoff) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (handoff) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (handoff) begin
        out_q <= skid_q;
      end
    end else if (t_v_q) begin
      if (handoff) begin
        out_q <= t_q;
      end else begin
        skid_q <= t_q;
      end
    end
  end

  assign out_valid_o         = out_v_q;
  assign new_first_moment_o  = out_q.mn;
  assign new_second_moment_o = out_q.rn;
  assign new_weight_o        = out_q.wn;
  assign saturated_o         = out_q.sat;

`ifndef SYNTHESIS
  // Skid only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full while output register empty");

  // A tail result arriving at a stalled output lands in the skid register
  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_stall_i && t_v_q && !skid_v_q) |=> skid_v_q)
    else $error("tail result lost under output stall");

  // Pipeline tail holds while the skid register is full
  a_tail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> $stable(t_v_q))
    else $error("pipeline advanced while skid register full");
`endif

endmodule

`default_nettype wire
